FILE: hdl/bmp_gray8_decoder_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef BMP_GRAY8_DECODER_UNIT_MACROS_SVH
`define BMP_GRAY8_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BMP_G8_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BMP_G8_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bmp_g8_pkg.sv
package bmp_g8_pkg;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_FHDR_SHORT = 4'd0;
  localparam logic [3:0] ERR_SIGNATURE  = 4'd1;
  localparam logic [3:0] ERR_INFO_SHORT = 4'd2;
  localparam logic [3:0] ERR_BAD_INFO   = 4'd3;
  localparam logic [3:0] ERR_BITCOUNT   = 4'd4;
  localparam logic [3:0] ERR_PAL_SIZE   = 4'd5;
  localparam logic [3:0] ERR_PAL_SHORT  = 4'd6;
  localparam logic [3:0] ERR_PIXELS     = 4'd7;
  localparam logic [3:0] ERR_OFFSET     = 4'd8;
  localparam logic [3:0] ERR_SIZE       = 4'd9;

  localparam logic [31:0] HDR_LEN   = 32'd54;
  localparam logic [15:0] SIG_BM    = 16'h4D42;
  localparam logic [15:0] DPI_RESET = 16'd500;

  // floor(t / 10000) = (t * DPI_RECIP) >> DPI_SHIFT for t below 2^30
  localparam logic [30:0] DPI_RECIP = 31'd1759218605;
  localparam int          DPI_SHIFT = 44;
  localparam logic [40:0] DPI_MIN   = 41'd10000;
  localparam logic [40:0] DPI_SAT   = 41'd655360000;

  // floor(x / 3) = (x * 683) >> 11 for x below 1024
  localparam logic [9:0] THIRD_RECIP = 10'd683;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] pixel_index;
    logic [7:0]  gray;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [15:0] resolution_dpi;
    logic [3:0]  error_code;
    logic        last_of_run;
  } result_t;

  function automatic result_t make_error(input logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t make_done(input logic [12:0] w, input logic [12:0] h,
                                        input logic [15:0] dpi);
    result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.image_width = w;
    r.image_height = h;
    r.resolution_dpi = dpi;
    return r;
  endfunction

  function automatic result_t make_pixel(input logic [23:0] idx, input logic [7:0] g);
    result_t r;
    r = '0;
    r.kind = KIND_PIXEL;
    r.pixel_index = idx;
    r.gray = g;
    return r;
  endfunction

endpackage

FILE: hdl/bmp_gray8_decoder_unit.sv
// Streaming decoder for 8-bit palette BMP files. File bytes enter on s_axis,
// one per cycle, with tlast on the final byte; the block checks the file and
// info headers, stores each palette entry as gray, skips to the pixel data
// and sends one result per pixel at its top-down row-major position, then an
// image-complete result with width, height and dpi, or an error result.
// Throughput is one byte per clock while the queue has room: a byte is held
// in the input register (while the palette RAM read for it completes) and its
// results are written to a 4-entry output queue. A byte that finishes an image
// gives two results, so the input side waits only while the queue has fewer
// than two free slots. The resolution is computed by a three-register pipeline
// from the stored pixels-per-metre fields, well before the image can complete.
module bmp_gray8_decoder_unit #(
  parameter int MAX_WIDTH       = 4096,
  parameter int MAX_HEIGHT      = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // file_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_index[23:0], gray[31:24], image_width[44:32], image_height[57:45],
  // resolution_dpi[73:58], error_code[77:74], zero fill [79:78]
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // default_dpi
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PCW = $clog2(PALETTE_ENTRIES + 1);
  localparam int AW  = $clog2(PALETTE_ENTRIES);

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_PAL  = 3'd1;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_PIX  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eof;
  logic       accept;
  logic       proc;
  logic       room2;

  logic [15:0] default_dpi;
  logic [15:0] dpi;
  logic [7:0]  pal_rdata;

  logic [2:0]    phase, phase_next;
  logic [31:0]   bpos, bpos_next;
  logic [31:0]   acc, acc_next;
  logic [31:0]   offset, offset_next;
  logic [WW-1:0] wreg, wreg_next;
  logic [HW-1:0] hreg, hreg_next;
  logic          rev_rows, rev_rows_next;
  logic [PCW-1:0] pcount, pcount_next;
  logic [31:0]   xppm, xppm_next;
  logic [31:0]   yppm, yppm_next;
  logic [9:0]    csum, csum_next;
  logic [WW-1:0] col, col_next;
  logic [HW-1:0] row, row_next;
  logic [1:0]    padc, padc_next;
  logic [23:0]   rstart, rstart_next;
  logic          sig_bad, sig_bad_next;
  logic          info_bad, info_bad_next;
  logic          bits_bad, bits_bad_next;
  logic          clr_bad, clr_bad_next;
  logic          size_bad, size_bad_next;

  logic          pal_we;
  logic [AW-1:0] pal_waddr;
  logic [7:0]    pal_wdata;

  bmp_g8_pkg::result_t r0, r1, q_out;
  logic [1:0] nres;
  logic [1:0] push_n;

  assign cfg_ready     = !rst;
  assign proc          = s1_valid && room2;
  assign s_axis_tready = !rst && (!s1_valid || proc);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_n        = proc ? nres : 2'd0;

  always_comb begin
    logic [31:0]   acc_new;
    logic [31:0]   bpos_inc;
    logic [31:0]   pal_end;
    logic [31:0]   mag;
    logic [31:0]   rel;
    logic [9:0]    tri_sum;
    logic [19:0]   tri_prod;
    logic [1:0]    pad;
    logic [WW-1:0] col_inc;
    logic [1:0]    padc_inc;
    logic [HW-1:0] row_inc;
    logic [2*HW+2*WW-1:0] start_prod;
    logic          start;
    logic          done;
    bmp_g8_pkg::result_t ev;
    logic          ev_valid;

    acc_new    = {s1_byte, acc[31:8]};
    bpos_inc   = bpos + 32'd1;
    pal_end    = bmp_g8_pkg::HDR_LEN + {{(30-PCW){1'b0}}, pcount, 2'b00};
    mag        = acc_new[31] ? (~acc_new + 32'd1) : acc_new;
    rel        = bpos - bmp_g8_pkg::HDR_LEN;
    tri_sum    = csum + {2'b0, s1_byte};
    tri_prod   = {10'd0, tri_sum} * {10'd0, bmp_g8_pkg::THIRD_RECIP};
    pad        = 2'd0 - wreg[1:0];
    col_inc    = col + {{(WW-1){1'b0}}, 1'b1};
    padc_inc   = padc + 2'd1;
    row_inc    = row + {{(HW-1){1'b0}}, 1'b1};
    start_prod = (2*HW+2*WW)'(hreg - {{(HW-1){1'b0}}, 1'b1}) * (2*HW+2*WW)'(wreg);
    start      = 1'b0;
    done       = 1'b0;
    ev         = '0;
    ev_valid   = 1'b0;

    phase_next     = phase;
    bpos_next      = bpos;
    acc_next       = acc;
    offset_next    = offset;
    wreg_next      = wreg;
    hreg_next      = hreg;
    rev_rows_next  = rev_rows;
    pcount_next    = pcount;
    xppm_next      = xppm;
    yppm_next      = yppm;
    csum_next      = csum;
    col_next       = col;
    row_next       = row;
    padc_next      = padc;
    rstart_next    = rstart;
    sig_bad_next   = sig_bad;
    info_bad_next  = info_bad;
    bits_bad_next  = bits_bad;
    clr_bad_next   = clr_bad;
    size_bad_next  = size_bad;
    pal_we         = 1'b0;
    pal_waddr      = rel[AW+1:2];
    pal_wdata      = tri_prod[18:11];
    r0             = '0;
    r1             = '0;
    nres           = 2'd0;

    case (phase)
      PH_HDR: begin
        acc_next  = acc_new;
        bpos_next = bpos_inc;
        case (bpos)
          32'd13: offset_next = acc_new;
          32'd17: if (acc_new != 32'd40) info_bad_next = 1'b1;
          32'd21: begin
            if (acc_new[31] || acc_new > 32'(MAX_WIDTH)) size_bad_next = 1'b1;
            else wreg_next = acc_new[WW-1:0];
          end
          32'd25: begin
            rev_rows_next = !acc_new[31];
            if (mag > 32'(MAX_HEIGHT)) size_bad_next = 1'b1;
            else hreg_next = mag[HW-1:0];
          end
          32'd27: if (acc_new[31:16] != 16'd1) info_bad_next = 1'b1;
          32'd29: if (acc_new[31:16] != 16'd8) bits_bad_next = 1'b1;
          32'd33: if (acc_new != 32'd0) info_bad_next = 1'b1;
          32'd41: xppm_next = acc_new;
          32'd45: yppm_next = acc_new;
          32'd49: begin
            if (acc_new > 32'(PALETTE_ENTRIES)) clr_bad_next = 1'b1;
            else if (acc_new == 32'd0) pcount_next = PCW'(PALETTE_ENTRIES);
            else pcount_next = acc_new[PCW-1:0];
          end
          default: ;
        endcase
        if (bpos_inc == 32'd2 && acc_new[31:16] != bmp_g8_pkg::SIG_BM) begin
          sig_bad_next = 1'b1;
        end
        if (bpos_inc == 32'd14 && sig_bad) begin
          ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_SIGNATURE);
          ev_valid = 1'b1;
        end
        if (bpos_inc == bmp_g8_pkg::HDR_LEN) begin
          ev_valid = 1'b1;
          if (info_bad) ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_BAD_INFO);
          else if (bits_bad) ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_BITCOUNT);
          else if (clr_bad) ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_PAL_SIZE);
          else if (size_bad) ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_SIZE);
          else begin
            ev_valid = 1'b0;
            phase_next = PH_PAL;
          end
        end
      end
      PH_PAL: begin
        case (rel[1:0])
          2'd0: csum_next = {2'b0, s1_byte};
          2'd1: csum_next = tri_sum;
          2'd2: pal_we = 1'b1;
          default: ;
        endcase
        bpos_next = bpos_inc;
        if (bpos_inc == pal_end) begin
          if (offset < bpos_inc) begin
            ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_OFFSET);
            ev_valid = 1'b1;
          end else if (wreg == '0 || hreg == '0) begin
            done = 1'b1;
          end else if (offset == bpos_inc) begin
            start = 1'b1;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        bpos_next = bpos_inc;
        if (bpos_inc == offset) start = 1'b1;
      end
      PH_PIX: begin
        if (col < wreg && 32'(s1_byte) >= 32'(pcount)) begin
          ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_PIXELS);
          ev_valid = 1'b1;
        end else begin
          if (col < wreg) begin
            r0 = bmp_g8_pkg::make_pixel(rstart + 24'(col), pal_rdata);
            nres = 2'd1;
            col_next = col_inc;
          end else begin
            padc_next = padc_inc;
          end
          if (col_next == wreg && padc_next == pad) begin
            col_next  = '0;
            padc_next = 2'd0;
            row_next  = row_inc;
            if (rev_rows) rstart_next = rstart - 24'(wreg);
            else rstart_next = rstart + 24'(wreg);
            if (row_inc == hreg) done = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (start) begin
      phase_next  = PH_PIX;
      col_next    = '0;
      row_next    = '0;
      padc_next   = 2'd0;
      rstart_next = rev_rows ? start_prod[23:0] : 24'd0;
    end
    if (done) begin
      ev = bmp_g8_pkg::make_done(13'(wreg), 13'(hreg), dpi);
      ev_valid = 1'b1;
    end
    if (ev_valid) begin
      phase_next = PH_DONE;
      if (nres == 2'd0) r0 = ev;
      else r1 = ev;
      nres = nres + 2'd1;
    end

    if (s1_eof) begin
      ev_valid = 1'b1;
      case (phase_next)
        PH_HDR: ev = bmp_g8_pkg::make_error(bpos_next < 32'd14 ?
                  bmp_g8_pkg::ERR_FHDR_SHORT : bmp_g8_pkg::ERR_INFO_SHORT);
        PH_PAL: ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_PAL_SHORT);
        PH_SKIP, PH_PIX: ev = bmp_g8_pkg::make_error(bmp_g8_pkg::ERR_PIXELS);
        default: ev_valid = 1'b0;
      endcase
      if (ev_valid) begin
        if (nres == 2'd0) r0 = ev;
        else r1 = ev;
        nres = nres + 2'd1;
      end
      // restart for the next file
      phase_next     = PH_HDR;
      bpos_next      = '0;
      acc_next       = '0;
      offset_next    = '0;
      wreg_next      = '0;
      hreg_next      = '0;
      rev_rows_next  = 1'b0;
      pcount_next    = '0;
      xppm_next      = '0;
      yppm_next      = '0;
      csum_next      = '0;
      col_next       = '0;
      row_next       = '0;
      padc_next      = '0;
      rstart_next    = '0;
      sig_bad_next   = 1'b0;
      info_bad_next  = 1'b0;
      bits_bad_next  = 1'b0;
      clr_bad_next   = 1'b0;
      size_bad_next  = 1'b0;
    end

    if (nres == 2'd1) r0.last_of_run = 1'b1;
    if (nres == 2'd2) r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= s_axis_tdata;
      s1_eof  <= s_axis_tlast;
    end
    if (rst) begin
      s1_valid    <= 1'b0;
      default_dpi <= bmp_g8_pkg::DPI_RESET;
      phase       <= PH_HDR;
      bpos        <= '0;
      acc         <= '0;
      offset      <= '0;
      wreg        <= '0;
      hreg        <= '0;
      rev_rows    <= 1'b0;
      pcount      <= '0;
      xppm        <= '0;
      yppm        <= '0;
      csum        <= '0;
      col         <= '0;
      row         <= '0;
      padc        <= '0;
      rstart      <= '0;
      sig_bad     <= 1'b0;
      info_bad    <= 1'b0;
      bits_bad    <= 1'b0;
      clr_bad     <= 1'b0;
      size_bad    <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (proc) s1_valid <= 1'b0;
      if (cfg_valid && cfg_ready) default_dpi <= cfg_data;
      if (proc) begin
        phase     <= phase_next;
        bpos      <= bpos_next;
        acc       <= acc_next;
        offset    <= offset_next;
        wreg      <= wreg_next;
        hreg      <= hreg_next;
        rev_rows  <= rev_rows_next;
        pcount    <= pcount_next;
        xppm      <= xppm_next;
        yppm      <= yppm_next;
        csum      <= csum_next;
        col       <= col_next;
        row       <= row_next;
        padc      <= padc_next;
        rstart    <= rstart_next;
        sig_bad   <= sig_bad_next;
        info_bad  <= info_bad_next;
        bits_bad  <= bits_bad_next;
        clr_bad   <= clr_bad_next;
        size_bad  <= size_bad_next;
      end
    end
  end

  bmp_g8_ram #(
    .WIDTH (8),
    .DEPTH (PALETTE_ENTRIES)
  ) u_pal (
    .clk     (clk),
    .wr_en   (proc && pal_we),
    .wr_addr (pal_waddr),
    .wr_data (pal_wdata),
    .rd_en   (accept),
    .rd_addr (s_axis_tdata[AW-1:0]),
    .rd_data (pal_rdata)
  );

  bmp_g8_dpi u_dpi (
    .clk         (clk),
    .x_ppm       (xppm),
    .y_ppm       (yppm),
    .default_dpi (default_dpi),
    .dpi         (dpi)
  );

  bmp_g8_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (r0),
    .push1     (r1),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (q_out)
  );

  assign m_axis_tuser = q_out.kind;
  assign m_axis_tlast = q_out.last_of_run;
  assign m_axis_tdata = {2'b00, q_out.error_code, q_out.resolution_dpi, q_out.image_height,
                         q_out.image_width, q_out.gray, q_out.pixel_index};

endmodule

FILE: hdl/bmp_g8_ram.sv
module bmp_g8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/bmp_g8_dpi.sv
module bmp_g8_dpi (
  input  logic        clk,
  input  logic [31:0] x_ppm,
  input  logic [31:0] y_ppm,
  input  logic [15:0] default_dpi,
  output logic [15:0] dpi
);

  logic signed [32:0] sum;
  logic signed [40:0] tval;
  logic               pos;
  logic               sat;
  logic [60:0]        prod;

  // round((X+Y) * 0.0254 / 2) as (s*127 + 5000) / 10000, one step per register
  always_ff @(posedge clk) begin
    sum  <= $signed({x_ppm[31], x_ppm}) + $signed({y_ppm[31], y_ppm});
    tval <= ($signed({{8{sum[32]}}, sum}) <<< 7) - $signed({{8{sum[32]}}, sum})
            + $signed(41'd5000);
    pos  <= tval >= $signed(bmp_g8_pkg::DPI_MIN);
    sat  <= tval >= $signed(bmp_g8_pkg::DPI_SAT);
    prod <= {31'd0, tval[29:0]} * {30'd0, bmp_g8_pkg::DPI_RECIP};
  end

  always_comb begin
    if (!pos) begin
      dpi = default_dpi;
    end else if (sat) begin
      dpi = 16'hFFFF;
    end else begin
      dpi = prod[bmp_g8_pkg::DPI_SHIFT+15:bmp_g8_pkg::DPI_SHIFT];
    end
  end

endmodule

FILE: hdl/bmp_g8_outq.sv
module bmp_g8_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_n,
  input  bmp_g8_pkg::result_t   push0,
  input  bmp_g8_pkg::result_t   push1,
  output logic                  room2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bmp_g8_pkg::result_t   out_data
);

  bmp_g8_pkg::result_t entry [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign out_data  = entry[rptr];
  assign room2     = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      entry[wptr + 2'd1] <= push1;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_n;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

FILE: hdl/bmp_g8_checker.sv
`include "bmp_gray8_decoder_unit_macros.svh"

module bmp_g8_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  `BMP_G8_ASSERT_IMP(a_kind_legal, clk, rst, m_axis_tvalid, m_axis_tuser == bmp_g8_pkg::KIND_PIXEL || m_axis_tuser == bmp_g8_pkg::KIND_DONE || m_axis_tuser == bmp_g8_pkg::KIND_ERROR, "undefined result kind")
  `BMP_G8_ASSERT_IMP(a_end_last, clk, rst, m_axis_tvalid && m_axis_tuser != bmp_g8_pkg::KIND_PIXEL, m_axis_tlast, "complete or error request not last of run")
  `BMP_G8_ASSERT_IMP(a_pixel_clean, clk, rst, m_axis_tvalid && m_axis_tuser == bmp_g8_pkg::KIND_PIXEL, m_axis_tdata[79:32] == 48'd0, "pixel request carries image fields")
  `BMP_G8_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result request changed")

endmodule

bind bmp_gray8_decoder_unit bmp_g8_checker u_bmp_g8_checker (.*);
